// ----- hw/rtl/trd_pkg.sv -----
package trd_pkg;

	// readout word type codes, bits 30-27 of a defining word
	typedef enum logic [3:0] {
		TYPE_BLOCK_HDR = 4'd0,
		TYPE_BLOCK_TRL = 4'd1,
		TYPE_EVENT_HDR = 4'd2,
		TYPE_TRIG_TIME = 4'd3,
		TYPE_UNDEF_4   = 4'd4,
		TYPE_UNDEF_5   = 4'd5,
		TYPE_UNDEF_6   = 4'd6,
		TYPE_UNDEF_7   = 4'd7,
		TYPE_UNDEF_8   = 4'd8,
		TYPE_UNDEF_9   = 4'd9,
		TYPE_UNDEF_10  = 4'd10,
		TYPE_UNDEF_11  = 4'd11,
		TYPE_CLUSTER   = 4'd12,
		TYPE_TRIG_DEC  = 4'd13,
		TYPE_NOT_VALID = 4'd14,
		TYPE_FILLER    = 4'd15
	} word_type_t;

	// record kind on the output
	typedef enum logic [3:0] {
		KIND_IGNORED   = 4'd0,
		KIND_REJECTED  = 4'd1,
		KIND_BLOCK_HDR = 4'd2,
		KIND_BLOCK_TRL = 4'd3,
		KIND_EVENT_HDR = 4'd4,
		KIND_TRIG_TIME = 4'd5,
		KIND_CLUS_W1   = 4'd6,
		KIND_CLUS_W2   = 4'd7,
		KIND_TRIG_DEC  = 4'd8
	} kind_t;

	// config register indexes
	localparam logic CFG_SLOT_ID  = 1'b0;
	localparam logic CFG_HCAL_DET = 1'b1;

	localparam logic [4:0] SLOT_ID_RST  = 5'd0;
	localparam logic [3:0] HCAL_DET_RST = 4'd11;

	localparam int OUT_DATA_W = 144;

	typedef struct packed {
		logic [4:0] slot_id;
		logic [3:0] hcal_det;
	} cfg_t;

	typedef struct packed {
		word_type_t  cur_type;
		logic        slot_matched;
		logic [3:0]  det_id;
		logic [23:0] time_lo;
		logic [23:0] time_hi;
	} dec_state_t;

	typedef struct packed {
		kind_t       kind;
		logic [4:0]  id_value;
		logic [9:0]  events_per_block;
		logic [7:0]  block_count;
		logic [21:0] count_value;
		logic [47:0] trigger_time;
		logic [15:0] cluster_energy;
		logic [4:0]  cluster_column;
		logic [6:0]  cluster_row;
		logic [3:0]  cluster_hits;
		logic [10:0] item_time;
		logic [5:0]  trigger_pattern;
	} record_t;

endpackage

// ----- hw/rtl/trd_cfg_regs.sv -----
module trd_cfg_regs (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic          cfg_addr,
	input  logic [4:0]    cfg_data,
	output trd_pkg::cfg_t cfg
);
	import trd_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.slot_id  <= SLOT_ID_RST;
			cfg_q.hcal_det <= HCAL_DET_RST;
		end else if (cfg_valid) begin
			unique case (cfg_addr)
				CFG_SLOT_ID:  cfg_q.slot_id  <= cfg_data;
				CFG_HCAL_DET: cfg_q.hcal_det <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

endmodule

// ----- hw/rtl/trd_decode.sv -----
module trd_decode (
	input  logic                word,
	input  logic [31:0]         data,
	input  logic                clear_first,
	input  trd_pkg::cfg_t       cfg,
	input  trd_pkg::dec_state_t st,
	output trd_pkg::dec_state_t st_nxt,
	output trd_pkg::record_t    rec
);
	import trd_pkg::*;

	logic       defining;
	word_type_t typ;
	logic       matched;
	logic       is_hcal_w1;
	logic       is_hcal_w2;
	logic [4:0] hdr_slot;

	// "word" strobes that data holds a valid item; nothing changes otherwise
	always_comb begin
		defining   = data[31];
		hdr_slot   = data[26:22];
		typ        = clear_first ? TYPE_FILLER : st.cur_type;
		if (defining) typ = word_type_t'(data[30:27]);
		matched    = clear_first ? 1'b0 : st.slot_matched;
		is_hcal_w1 = (data[26:23] == cfg.hcal_det);
		is_hcal_w2 = (st.det_id == cfg.hcal_det);

		st_nxt              = st;
		st_nxt.cur_type     = typ;
		st_nxt.slot_matched = matched;
		rec                 = '0;

		if (!matched && typ != TYPE_BLOCK_HDR) begin
			rec.kind = KIND_REJECTED;
		end else begin
			unique case (typ)
				TYPE_BLOCK_HDR: begin
					if (defining) begin
						st_nxt.slot_matched = (hdr_slot == cfg.slot_id);
						rec.id_value        = hdr_slot;
						if (hdr_slot == cfg.slot_id) begin
							rec.kind             = KIND_BLOCK_HDR;
							rec.events_per_block = data[17:8];
							rec.block_count      = data[7:0];
						end else begin
							rec.kind = KIND_REJECTED;
						end
					end
				end
				TYPE_BLOCK_TRL: begin
					rec.kind        = KIND_BLOCK_TRL;
					rec.id_value    = hdr_slot;
					rec.count_value = data[21:0];
				end
				TYPE_EVENT_HDR: begin
					rec.kind        = KIND_EVENT_HDR;
					rec.count_value = data[21:0];
				end
				TYPE_TRIG_TIME: begin
					if (defining) st_nxt.time_lo = data[23:0];
					else          st_nxt.time_hi = data[23:0];
					rec.kind         = KIND_TRIG_TIME;
					rec.trigger_time = {st_nxt.time_hi, st_nxt.time_lo};
				end
				TYPE_CLUSTER: begin
					if (defining) begin
						st_nxt.det_id  = data[26:23];
						rec.kind       = KIND_CLUS_W1;
						rec.id_value   = {1'b0, data[26:23]};
						rec.cluster_energy = is_hcal_w1 ? data[15:0]
						                                : {2'b00, data[13:0]};
					end else begin
						rec.kind     = KIND_CLUS_W2;
						rec.id_value = {1'b0, st.det_id};
						if (is_hcal_w2) begin
							rec.cluster_column = {1'b0, data[23:20]};
							rec.cluster_row    = {2'b00, data[19:15]};
						end else begin
							rec.cluster_column = data[26:22];
							rec.cluster_row    = data[21:15];
						end
						rec.cluster_hits = data[14:11];
						rec.item_time    = data[10:0];
					end
				end
				TYPE_TRIG_DEC: begin
					if (defining) begin
						rec.kind            = KIND_TRIG_DEC;
						rec.item_time       = {4'b0000, data[22:16]};
						rec.trigger_pattern = data[5:0];
					end
				end
				default: ;
			endcase
		end

		if (!word) st_nxt = st;
	end

endmodule

// ----- hw/rtl/trigger_readout_word_decoder.sv -----
// Channel  Dir  Signals                      Contents
// s_*      in   tvalid tready tdata tuser    readout word, clear flag
// m_*      out  tvalid tready tdata tuser    decoded record, record kind
// cfg_*    in   valid ready addr data        config register writes
//
// One word per clock sustained while m_tready is high. A word passes an
// input register, decode and sticky-state update, then the output register.
// The sticky state (type, slot match, detector id, time halves) updates
// as a word moves from the input register into the output register.
// s_tready drops only while both the input and output registers are full
// and m_tready is low. Reset clears valid flags, state and config.
module trigger_readout_word_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] word
	input  logic        s_tuser,   // [0] clear_first
	output logic        m_tvalid,
	input  logic        m_tready,
	// [4:0] id_value, [14:5] events_per_block, [22:15] block_count,
	// [44:23] count_value, [92:45] trigger_time, [108:93] cluster_energy,
	// [113:109] cluster_column, [120:114] cluster_row, [124:121] cluster_hits,
	// [135:125] item_time, [141:136] trigger_pattern, [143:142] zero
	output logic [trd_pkg::OUT_DATA_W-1:0] m_tdata,
	output logic [3:0]  m_tuser,   // [3:0] kind
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_addr,
	input  logic [4:0]  cfg_data
);
	import trd_pkg::*;

	cfg_t       cfg;
	dec_state_t st_q;
	dec_state_t st_nxt;
	record_t    rec;
	record_t    rec_s2;

	logic        vld_s1;
	logic [31:0] word_s1;
	logic        clr_s1;
	logic        vld_s2;
	logic        adv;

	trd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_addr  (cfg_addr),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// output register moves when empty or being drained
	assign adv      = !vld_s2 || m_tready;
	assign s_tready = !vld_s1 || adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			word_s1 <= s_tdata;
			clr_s1  <= s_tuser;
		end
	end

	// decode; state commits only when the word moves on
	trd_decode u_dec (
		.word        (vld_s1 && adv),
		.data        (word_s1),
		.clear_first (clr_s1),
		.cfg         (cfg),
		.st          (st_q),
		.st_nxt      (st_nxt),
		.rec         (rec)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.cur_type     <= TYPE_FILLER;
			st_q.slot_matched <= 1'b0;
			st_q.det_id       <= '0;
			st_q.time_lo      <= '0;
			st_q.time_hi      <= '0;
		end else begin
			st_q <= st_nxt;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && vld_s1) begin
			rec_s2 <= rec;
		end
	end

	assign m_tvalid = vld_s2;
	assign m_tuser  = rec_s2.kind;
	assign m_tdata  = {2'b00, rec_s2.trigger_pattern, rec_s2.item_time,
	                   rec_s2.cluster_hits, rec_s2.cluster_row, rec_s2.cluster_column,
	                   rec_s2.cluster_energy, rec_s2.trigger_time, rec_s2.count_value,
	                   rec_s2.block_count, rec_s2.events_per_block, rec_s2.id_value};

	// back-pressure only comes from a stalled, full output register
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (m_tvalid && !m_tready))
		else $error("input stalled without output stall");

	// a delivered block header leaves the slot marked as matched
	a_hdr_match: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == KIND_BLOCK_HDR) |-> st_q.slot_matched)
		else $error("block header emitted but slot not matched");

	// a rejected word carries nothing but the slot
	a_rej_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == KIND_REJECTED) |-> (m_tdata[143:5] == '0))
		else $error("rejected record has payload");

	// state holds while the output register is stalled
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> $stable(st_q))
		else $error("state changed during output stall");

endmodule

// ----- tb/sv/trigger_readout_word_decoder_tb.sv -----
`timescale 1ns / 1ps

module trigger_readout_word_decoder_tb;
	import trd_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 300;

	typedef struct {
		logic [31:0] word;
		logic        clear;
	} readout_word_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [31:0]           s_tdata   = '0;
	logic                  s_tuser   = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [3:0]            m_tuser;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic                  cfg_addr  = CFG_SLOT_ID;
	logic [4:0]            cfg_data  = '0;

	trigger_readout_word_decoder dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// words waiting to go out, records waiting to come back
	readout_word_t pending_words[$];
	record_t       expected_records[$];
	readout_word_t next_word;

	// decoder copy: config and sticky state
	logic [4:0]  cfg_slot = SLOT_ID_RST;
	logic [3:0]  cfg_hcal = HCAL_DET_RST;
	word_type_t  cur_type = TYPE_FILLER;
	logic        slot_ok  = 1'b0;
	logic [3:0]  det_id   = '0;
	logic [23:0] time_lo  = '0;
	logic [23:0] time_hi  = '0;

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int hold_requests  = 0;
	int hold_served    = 0;
	int hold_left      = 0;
	int cycle_count    = 0;
	int mismatches     = 0;
	int words_sent     = 0;
	int records_seen   = 0;
	int made           = 0;
	int kind_hits[9];

	// one word through the decoder: updates sticky state, returns the record
	function automatic record_t decode_word(logic [31:0] w, logic clr);
		record_t r;
		logic    defining;
		r = '0;
		r.kind = KIND_IGNORED;
		defining = w[31];
		if (clr) begin
			cur_type = TYPE_FILLER;
			slot_ok  = 1'b0;
		end
		if (defining)
			cur_type = word_type_t'(w[30:27]);
		if (!slot_ok && cur_type != TYPE_BLOCK_HDR) begin
			r.kind = KIND_REJECTED;
		end else begin
			case (cur_type)
			TYPE_BLOCK_HDR: begin
				if (defining) begin
					slot_ok = (w[26:22] == cfg_slot);
					r.id_value = w[26:22];
					if (slot_ok) begin
						r.kind = KIND_BLOCK_HDR;
						r.events_per_block = w[17:8];
						r.block_count = w[7:0];
					end else begin
						r.kind = KIND_REJECTED;
					end
				end
			end
			TYPE_BLOCK_TRL: begin
				r.kind = KIND_BLOCK_TRL;
				r.id_value = w[26:22];
				r.count_value = w[21:0];
			end
			TYPE_EVENT_HDR: begin
				r.kind = KIND_EVENT_HDR;
				r.count_value = w[21:0];
			end
			TYPE_TRIG_TIME: begin
				if (defining)
					time_lo = w[23:0];
				else
					time_hi = w[23:0];
				r.kind = KIND_TRIG_TIME;
				r.trigger_time = {time_hi, time_lo};
			end
			TYPE_CLUSTER: begin
				if (defining) begin
					det_id = w[26:23];
					r.kind = KIND_CLUS_W1;
					r.id_value = {1'b0, det_id};
					r.cluster_energy = (det_id == cfg_hcal) ? w[15:0] : {2'b00, w[13:0]};
				end else begin
					r.kind = KIND_CLUS_W2;
					r.id_value = {1'b0, det_id};
					if (det_id == cfg_hcal) begin
						r.cluster_column = {1'b0, w[23:20]};
						r.cluster_row = {2'b00, w[19:15]};
					end else begin
						r.cluster_column = w[26:22];
						r.cluster_row = w[21:15];
					end
					r.cluster_hits = w[14:11];
					r.item_time = w[10:0];
				end
			end
			TYPE_TRIG_DEC: begin
				if (defining) begin
					r.kind = KIND_TRIG_DEC;
					r.item_time = {4'b0000, w[22:16]};
					r.trigger_pattern = w[5:0];
				end
			end
			default: ;
			endcase
		end
		return r;
	endfunction

	// sender: holds a word until taken, random gaps between words
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				expected_records.insert(expected_records.size(),
					decode_word(s_tdata, s_tuser));
				words_sent++;
			end
			if (!s_tvalid || s_tready) begin
				if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					next_word = pending_words.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= next_word.word;
					s_tuser  <= next_word.clear;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(string name, logic [47:0] want, logic [47:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endtask

	task automatic check_record();
		record_t want;
		if (expected_records.size() == 0) begin
			mismatches++;
			$display("%0t: unexpected record, expected none, actual kind %0h data %0h",
				$time, m_tuser, m_tdata);
		end else begin
			want = expected_records.pop_front();
			records_seen++;
			kind_hits[int'(want.kind)]++;
			check_field("kind", 48'(want.kind), 48'(m_tuser));
			check_field("id_value", 48'(want.id_value), 48'(m_tdata[4:0]));
			check_field("events_per_block", 48'(want.events_per_block),
				48'(m_tdata[14:5]));
			check_field("block_count", 48'(want.block_count), 48'(m_tdata[22:15]));
			check_field("count_value", 48'(want.count_value), 48'(m_tdata[44:23]));
			check_field("trigger_time", want.trigger_time, m_tdata[92:45]);
			check_field("cluster_energy", 48'(want.cluster_energy), 48'(m_tdata[108:93]));
			check_field("cluster_column", 48'(want.cluster_column),
				48'(m_tdata[113:109]));
			check_field("cluster_row", 48'(want.cluster_row), 48'(m_tdata[120:114]));
			check_field("cluster_hits", 48'(want.cluster_hits), 48'(m_tdata[124:121]));
			check_field("item_time", 48'(want.item_time), 48'(m_tdata[135:125]));
			check_field("trigger_pattern", 48'(want.trigger_pattern),
				48'(m_tdata[141:136]));
		end
	endtask

	// receiver: checks each record, random stalls, long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			hold_left <= 0;
		end else begin
			if (m_tvalid && m_tready)
				check_record();
			if (hold_served != hold_requests) begin
				hold_served <= hold_requests;
				hold_left <= HOLD_CYCLES;
				m_tready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	function automatic logic [31:0] def_word(word_type_t t, logic [26:0] payload);
		return {1'b1, t, payload};
	endfunction

	function automatic logic [31:0] cont_word();
		return {1'b0, 31'($urandom)};
	endfunction

	function automatic void push_word(logic [31:0] w, logic clr);
		readout_word_t item;
		item.word = w;
		item.clear = clr;
		pending_words.insert(pending_words.size(), item);
		made++;
	endfunction

	task automatic write_reg(logic addr, logic [4:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_addr <= addr;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (addr == CFG_SLOT_ID)
			cfg_slot = value;
		else
			cfg_hcal = value[3:0];
		@(negedge clk);
	endtask

	task automatic wait_idle();
		while (pending_words.size() != 0 || s_tvalid || expected_records.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// one block: header, events with time/clusters/decisions, trailer
	task automatic push_block();
		logic [4:0] slot;
		logic [3:0] det;
		slot = ($urandom_range(7) == 0) ? 5'($urandom_range(31)) : cfg_slot;
		push_word(def_word(TYPE_BLOCK_HDR, {slot, 22'($urandom)}), $urandom_range(3) == 0);
		if ($urandom_range(5) == 0)
			push_word(cont_word(), 1'b0);
		repeat ($urandom_range(1, 3)) begin
			push_word(def_word(TYPE_EVENT_HDR, 27'($urandom)), 1'b0);
			if ($urandom_range(4) == 0)
				push_word(cont_word(), 1'b0);
			push_word(def_word(TYPE_TRIG_TIME, 27'($urandom)), 1'b0);
			push_word(cont_word(), 1'b0);
			repeat ($urandom_range(0, 3)) begin
				det = $urandom_range(1) ? cfg_hcal : 4'($urandom_range(15));
				push_word(def_word(TYPE_CLUSTER, {det, 23'($urandom)}), 1'b0);
				repeat ($urandom_range(1, 2))
					push_word(cont_word(), 1'b0);
			end
			push_word(def_word(TYPE_TRIG_DEC, 27'($urandom)), 1'b0);
			if ($urandom_range(4) == 0)
				push_word(cont_word(), 1'b0);
			// stray undefined / not-valid / filler word inside the event
			if ($urandom_range(5) == 0) begin
				push_word(def_word(word_type_t'($urandom_range(1) ?
					$urandom_range(TYPE_UNDEF_4, TYPE_UNDEF_11) :
					$urandom_range(TYPE_NOT_VALID, TYPE_FILLER)), 27'($urandom)), 1'b0);
				made--;
			end
		end
		push_word(def_word(TYPE_BLOCK_TRL, 27'($urandom)), 1'b0);
		if ($urandom_range(3) == 0)
			push_word(cont_word(), 1'b0);
	endtask

	task automatic push_random(int target);
		made = 0;
		while (made < target) begin
			if ($urandom_range(9) == 0)
				push_word($urandom, $urandom_range(15) == 0);
			else
				push_block();
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed words under reset config: slot 0, HCAL id 11
		send_idle_pct = 26;
		recv_stall_pct = 48;
		push_word({1'b0, 31'h0}, 1'b0);                                  // before any header
		push_word(def_word(TYPE_EVENT_HDR, 27'h7FFFFFF), 1'b0);          // rejected, defining
		push_word(def_word(TYPE_BLOCK_HDR, {5'd5, 22'h3FFFFF}), 1'b0);   // slot mismatch
		push_word({1'b0, 31'h7FFFFFFF}, 1'b0);                           // cont under header
		push_word(def_word(TYPE_BLOCK_HDR, {5'd0, 22'h3FFFFF}), 1'b0);   // matching header
		push_word({1'b0, 31'h7FFFFFFF}, 1'b0);
		push_word(def_word(TYPE_EVENT_HDR, 27'h7FFFFFF), 1'b0);
		push_word({1'b0, 31'h7FFFFFFF}, 1'b0);                           // event hdr cont
		push_word(def_word(TYPE_TRIG_TIME, 27'h0FFFFFF), 1'b0);          // low half
		push_word({1'b0, 31'h7FABCDEF}, 1'b0);                           // high half
		push_word(def_word(TYPE_CLUSTER, {4'd11, 23'h7FFFFF}), 1'b0);    // HCAL layout
		push_word({1'b0, 31'h7FFFFFFF}, 1'b0);
		push_word(def_word(TYPE_CLUSTER, {4'd3, 23'h7FFFFF}), 1'b0);     // ECAL layout
		push_word({1'b0, 31'h7FFFFFFF}, 1'b0);
		push_word(def_word(TYPE_TRIG_DEC, 27'h7FFFFFF), 1'b0);
		push_word({1'b0, 31'h7FFFFFFF}, 1'b0);                           // cont under decision
		push_word(def_word(TYPE_UNDEF_4, 27'h0), 1'b0);
		push_word(def_word(TYPE_UNDEF_11, 27'h7FFFFFF), 1'b0);
		push_word(def_word(TYPE_NOT_VALID, 27'h7FFFFFF), 1'b0);
		push_word(def_word(TYPE_FILLER, 27'h7FFFFFF), 1'b0);
		push_word(def_word(TYPE_BLOCK_TRL, {5'd31, 22'h3FFFFF}), 1'b0);
		push_word({1'b0, 31'h0}, 1'b0);                                  // trailer cont
		push_word(def_word(TYPE_BLOCK_HDR, {5'd9, 22'h0}), 1'b0);        // mismatch drops match
		push_word(def_word(TYPE_EVENT_HDR, 27'h0), 1'b0);                // now rejected
		push_word(def_word(TYPE_BLOCK_HDR, {5'd0, 22'h0}), 1'b1);        // clear + header
		push_word({1'b0, 31'h12345}, 1'b1);                              // clear, then rejected
		wait_idle();

		// register extremes, sender idles lightly, receiver heavily
		write_reg(CFG_SLOT_ID, 5'd31);
		write_reg(CFG_HCAL_DET, 5'd0);
		push_random(360);
		wait_idle();

		// roles swapped
		send_idle_pct = 48;
		recv_stall_pct = 26;
		write_reg(CFG_SLOT_ID, 5'($urandom_range(31)));
		write_reg(CFG_HCAL_DET, 5'd15);
		push_random(360);
		wait_idle();

		// full rate, starting with a long receiver hold-off
		send_idle_pct = 0;
		recv_stall_pct = 0;
		write_reg(CFG_SLOT_ID, 5'($urandom_range(31)));
		write_reg(CFG_HCAL_DET, 5'($urandom_range(15)));
		hold_requests++;
		push_random(380);
		wait_idle();

		$display("Run covered %0d words under four register settings, %0d records checked",
			words_sent, records_seen);
		$display("headers %0d, rejected %0d, ignored %0d, cluster words %0d, time words %0d",
			kind_hits[KIND_BLOCK_HDR], kind_hits[KIND_REJECTED], kind_hits[KIND_IGNORED],
			kind_hits[KIND_CLUS_W1] + kind_hits[KIND_CLUS_W2], kind_hits[KIND_TRIG_TIME]);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
